>>> sv/lsp_pkg.sv
// Shared types and codes for the LIFO stack with palindrome check.
package lsp_pkg;

	localparam int WORD_W   = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 4;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic signed [WORD_W-1:0] word_t;

	localparam kind_t KIND_PUSH    = 2'd0;
	localparam kind_t KIND_POP     = 2'd1;
	localparam kind_t KIND_PALIN   = 2'd2;
	localparam kind_t KIND_DISPLAY = 2'd3;

	localparam status_t ST_PUSHED    = 4'd0;
	localparam status_t ST_OVERFLOW  = 4'd1;
	localparam status_t ST_POPPED    = 4'd2;
	localparam status_t ST_UNDERFLOW = 4'd3;
	localparam status_t ST_PALIN     = 4'd4;
	localparam status_t ST_NOT_PALIN = 4'd5;
	localparam status_t ST_NO_CHECK  = 4'd6;
	localparam status_t ST_ENTRY     = 4'd7;
	localparam status_t ST_EMPTY     = 4'd8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EMIT,
		S_POP,
		S_PAL,
		S_DISP
	} state_t;

endpackage

>>> sv/lsp_mem.sv
// Stack entry memory: one write port, two registered read ports.
module lsp_mem #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      wa,
	input  lsp_pkg::word_t                wd,
	input  logic                          rea,
	input  logic [$clog2(DEPTH)-1:0]      raa,
	output lsp_pkg::word_t                rda,
	input  logic                          reb,
	input  logic [$clog2(DEPTH)-1:0]      rab,
	output lsp_pkg::word_t                rdb
);
	import lsp_pkg::*;

	word_t mem_q [DEPTH];
	word_t rda_q;
	word_t rdb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rea) begin
			rda_q <= mem_q[raa];
		end
		if (reb) begin
			rdb_q <= mem_q[rab];
		end
	end

	assign rda = rda_q;
	assign rdb = rdb_q;

endmodule

>>> sv/lifo_stack_with_palindrome_check.sv
// Top level: bounded LIFO stack with pop, palindrome check and display walk.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | kind, push_value
//   out     | output    | out_valid/out_stall| status, data_value, last
//
// Push: the entry is written at accept, then S_EMIT loads the result. Pop: the read starts at accept, then S_POP.
// Palindrome: one entry pair per cycle through one comparator, from both ends inward, then S_EMIT.
// Display: one entry per cycle from the memory read port while the output is not stalled.
// Reset clears the fill count and the sequencer; entries are undefined until pushed.
// in_stall is high while an item is in work; out_stall freezes the display walk in place.
module lifo_stack_with_palindrome_check #(
	parameter int DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lsp_pkg::kind_t       kind,
	input  lsp_pkg::word_t       push_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lsp_pkg::status_t     status,
	output lsp_pkg::word_t       data_value,
	output logic                 last
);
	import lsp_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
	status_t pend_st_q, pend_st_d;

	logic out_valid_q;
	status_t out_st_q, out_st_d;
	word_t out_data_q, out_data_d;
	logic out_last_q, out_last_d;
	logic out_load, out_free;

	logic we, rea, reb;
	logic [IW-1:0] wa, raa, rab;
	word_t rda, rdb;

	logic in_acc;
	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] pair_gap;
	logic [IW-1:0] lo_inc, hi_dec;

	lsp_mem #(.DEPTH(DEPTH)) u_mem (
		.clk (clk),
		.we  (we),
		.wa  (wa),
		.wd  (push_value),
		.rea (rea),
		.raa (raa),
		.rda (rda),
		.reb (reb),
		.rab (rab),
		.rdb (rdb)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cnt_dec  = cnt_q - CW'(1);
	assign lo_inc   = lo_q + IW'(1);
	assign hi_dec   = hi_q - IW'(1);
	assign pair_gap = CW'(hi_q) - CW'(lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		pend_st_q <= pend_st_d;
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		pend_st_d  = pend_st_q;
		out_load   = 1'b0;
		out_st_d   = pend_st_q;
		out_data_d = '0;
		out_last_d = 1'b1;
		we         = 1'b0;
		wa         = cnt_q[IW-1:0];
		rea        = 1'b0;
		raa        = cnt_dec[IW-1:0];
		reb        = 1'b0;
		rab        = cnt_dec[IW-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_PUSH: begin
							state_d = S_EMIT;
							if (cnt_q >= CW'(DEPTH)) begin
								pend_st_d = ST_OVERFLOW;
							end else begin
								we        = 1'b1;
								cnt_d     = cnt_q + CW'(1);
								pend_st_d = ST_PUSHED;
							end
						end
						KIND_POP: begin
							if (cnt_q == '0) begin
								pend_st_d = ST_UNDERFLOW;
								state_d   = S_EMIT;
							end else begin
								rea     = 1'b1;
								cnt_d   = cnt_dec;
								state_d = S_POP;
							end
						end
						KIND_PALIN: begin
							if (cnt_q < CW'(2)) begin
								pend_st_d = ST_NO_CHECK;
								state_d   = S_EMIT;
							end else begin
								rea     = 1'b1;
								raa     = '0;
								reb     = 1'b1;
								lo_d    = '0;
								hi_d    = cnt_dec[IW-1:0];
								state_d = S_PAL;
							end
						end
						default: begin
							if (cnt_q == '0) begin
								pend_st_d = ST_EMPTY;
								state_d   = S_EMIT;
							end else begin
								rea     = 1'b1;
								hi_d    = cnt_dec[IW-1:0];
								state_d = S_DISP;
							end
						end
					endcase
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_POP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_st_d   = ST_POPPED;
					out_data_d = rda;
					state_d    = S_IDLE;
				end
			end
			S_PAL: begin
				if (rda != rdb) begin
					pend_st_d = ST_NOT_PALIN;
					state_d   = S_EMIT;
				end else if (pair_gap <= CW'(2)) begin
					pend_st_d = ST_PALIN;
					state_d   = S_EMIT;
				end else begin
					rea  = 1'b1;
					raa  = lo_inc;
					reb  = 1'b1;
					rab  = hi_dec;
					lo_d = lo_inc;
					hi_d = hi_dec;
				end
			end
			S_DISP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_st_d   = ST_ENTRY;
					out_data_d = rda;
					out_last_d = (hi_q == '0);
					if (hi_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rea  = 1'b1;
						raa  = hi_dec;
						hi_d = hi_dec;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_st_q   <= out_st_d;
			out_data_q <= out_data_d;
			out_last_q <= out_last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_st_q;
	assign data_value = out_data_q;
	assign last       = out_last_q;

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind == KIND_PUSH && cnt_q < CW'(DEPTH)) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("push did not grow the stack");

	a_pal_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAL) |-> (cnt_q >= CW'(2) && hi_q > lo_q))
		else $error("palindrome walk with bad pair");

	a_disp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP) |-> (CW'(hi_q) < cnt_q))
		else $error("display index beyond fill count");

endmodule
